// ----- hw/rtl/lut3t_pkg.sv -----
// Shared types and fixed constants of the 3D LUT trilinear resampler.
package lut3t_pkg;

  localparam int VAL_W = 16;
  localparam int OUT_W = 12;
  localparam int GRID_W = 5;
  localparam int ADDR_W = 16;
  localparam int ENTRY_W = 3 * VAL_W;
  localparam int RECIP_SH = 24;
  localparam logic [VAL_W-1:0] FULL16 = 16'hFFFF;

  typedef enum logic {
    FUNC_WRITE   = 1'b0,
    FUNC_COMPUTE = 1'b1
  } func_t;

endpackage

// ----- hw/rtl/lut3d_trilinear_resampler.sv -----
// Top level of the 3D LUT trilinear resampler with eight parallel corner lanes.
//
// Usage. One input channel (in_valid, in_stall) carries two kinds of
// transaction. With func at FUNC_WRITE the entry lut_red/green/blue is stored
// at lut_address (red fastest, then green, then blue); addresses beyond the
// source LUT are dropped and no result is produced. With func at
// FUNC_COMPUTE the destination grid point grid_red/green/blue is mapped onto
// the source grid, the eight bracketing entries are blended trilinearly, and
// one result transaction leaves on the output channel (out_valid, out_stall):
// the bypass value and the gamut-scaled value, each rounded to 12 bits.
// The source LUT is split into eight parity banks, one per corner lane, so
// all eight corners are read in the same cycle and a new transaction can be
// taken every cycle while in_stall is low. A compute result passes 13 stages
// of capture, address mapping, bank read, weighting, the adder tree and
// ratio scaling, then 12 stages of the pipelined rounding divider.
// Writes reach the banks at the same stage where computes read them, so a
// compute sees every write accepted before it.
// The output register is backed by a one-entry skid buffer; in_stall is
// raised only while that buffer is occupied, in which case the whole pipe
// holds its contents. Reset clears the valid flags of the pipe and of the
// output; the LUT contents are not cleared and must be loaded before use.
module lut3d_trilinear_resampler
  import lut3t_pkg::*;
#(
  parameter int SRC_GRID = 33,
  parameter int DST_GRID = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              func,
  input  logic [ADDR_W-1:0] lut_address,
  input  logic [VAL_W-1:0]  lut_red,
  input  logic [VAL_W-1:0]  lut_green,
  input  logic [VAL_W-1:0]  lut_blue,
  input  logic [GRID_W-1:0] grid_red,
  input  logic [GRID_W-1:0] grid_green,
  input  logic [GRID_W-1:0] grid_blue,
  input  logic [VAL_W-1:0]  gamut_red,
  input  logic [VAL_W-1:0]  gamut_green,
  input  logic [VAL_W-1:0]  gamut_blue,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  out_red,
  output logic [OUT_W-1:0]  out_green,
  output logic [OUT_W-1:0]  out_blue,
  output logic [OUT_W-1:0]  bypass_red,
  output logic [OUT_W-1:0]  bypass_green,
  output logic [OUT_W-1:0]  bypass_blue
);

  // Widths that follow from the two grid sizes.
  localparam int NW = $clog2(SRC_GRID);
  localparam int WW = $clog2(DST_GRID + 1);
  localparam int AW = $clog2(DST_GRID * SRC_GRID + 1);
  localparam int HN = (SRC_GRID + 1) / 2;
  localparam int HW = (HN > 1) ? $clog2(HN) : 1;
  localparam int BDEPTH = HN * HN * HN;
  localparam int BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int PW = $clog2(DST_GRID * DST_GRID * DST_GRID + 1);
  localparam int SW = VAL_W + PW;
  localparam int DVW = 2 * VAL_W + PW;
  localparam int R1W = $clog2(SRC_GRID * SRC_GRID + 1);
  localparam int SRC2 = SRC_GRID * SRC_GRID;
  localparam int SRC3 = SRC2 * SRC_GRID;

  // Reciprocals for division by the grid constants, corrected by one step.
  localparam int MD = (1 << RECIP_SH) / DST_GRID;
  localparam int MB = (1 << RECIP_SH) / SRC2;
  localparam int MS = (1 << RECIP_SH) / SRC_GRID;

  // Denominators of the final ratios.
  localparam logic [63:0] D64 = 64'(DST_GRID);
  localparam logic [63:0] F64 = 64'(FULL16);
  localparam logic [63:0] D3C = F64 * D64 * D64 * D64;
  localparam logic [63:0] D4C = D3C * D64;
  localparam logic [63:0] DMC = F64 * F64 * D64 * D64;

  // Pipe depth up to the divider input, then one divider stage per result bit.
  localparam int PRE = 13;
  localparam int LAT = PRE + OUT_W;
  localparam int MLEN = 10;

  typedef struct packed {
    logic [2:0][VAL_W-1:0] gam;
    logic [2:0][WW-1:0]    kp1;
    logic                  any_zero;
  } meta_t;

  logic adv;
  logic skid_valid;

  // Stage 1: captured transaction.
  logic [LAT-1:0]          cv;
  logic [5:0]              wv;
  logic [ADDR_W-1:0]       addr1;
  logic [ENTRY_W-1:0]      wd [6];
  logic [2:0][GRID_W-1:0]  grid1;
  logic [2:0][VAL_W-1:0]   gam1;

  // Axis mapping.
  logic [2:0][WW-1:0]      kp1_n;
  logic [2:0][AW-1:0]      prodk_n;
  logic [2:0]              neg2;
  logic [2:0][AW-1:0]      num2;
  logic [2:0][NW-1:0]      lo0_2;
  meta_t                   meta_n;
  meta_t                   meta_l [MLEN];
  logic [2:0][NW-1:0]      lo3, hi3, lo4, hi4, lo5, hi5;
  logic [2:0][WW-1:0]      wlo3, whi3, wlo4, whi4, wlo5, whi5;

  // Write address decomposition.
  logic                    ok2, ok3, ok4, ok5, ok6;
  logic [ADDR_W-1:0]       addr2;
  logic [ADDR_W-1:0]       qb2;
  logic [NW-1:0]           b3, b4, b5;
  logic [R1W-1:0]          rem3, rem4;
  logic [NW-1:0]           qg4;
  logic [NW-1:0]           g5, r5;
  logic [BAW-1:0]          wpart6;
  logic [HW-1:0]           bh6;
  logic [2:0]              wbank6;
  logic [BAW-1:0]          waddr6;
  logic                    ram_we;

  // Lanes and merge.
  logic [2:0][SW-1:0]      lane_prod [8];
  logic [2:0][SW-1:0]      sum4 [4];
  logic [2:0][SW-1:0]      sum2 [2];
  logic [2:0][SW-1:0]      sum1;

  // Scaling and divider inputs.
  logic [2:0][DVW-1:0]     nm12, dm12, nb12, db12;
  logic [2:0][DVW+12:0]    nm13, nb13;
  logic [2:0][DVW:0]       dm13, db13;
  logic [2:0][OUT_W-1:0]   qm, qb;

  // Output register and skid buffer.
  logic [5:0][OUT_W-1:0]   res;
  logic [5:0][OUT_W-1:0]   skid_data;
  logic [5:0][OUT_W-1:0]   out_data;
  logic                    out_free;

  // The pipe only holds while a result sits in the skid buffer.
  assign adv = !skid_valid;
  assign in_stall = skid_valid;

  // Valid flags of compute and write transactions along the pipe.
  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= '0;
      wv <= '0;
    end else if (adv) begin
      cv <= {cv[LAT-2:0], in_valid && (func == FUNC_COMPUTE)};
      wv <= {wv[4:0], in_valid && (func == FUNC_WRITE)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      addr1 <= lut_address;
      wd[0] <= {lut_blue, lut_green, lut_red};
      for (int i = 1; i < 6; i++) begin
        wd[i] <= wd[i-1];
      end
      grid1 <= {grid_blue, grid_green, grid_red};
      gam1 <= {gamut_blue, gamut_green, gamut_red};
    end
  end

  // Stage 2: clamp the grid index and place its coordinate on the source grid.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (32'(grid1[a]) > 32'(DST_GRID - 1)) begin
        kp1_n[a] = WW'(DST_GRID);
      end else begin
        kp1_n[a] = WW'(grid1[a]) + WW'(1);
      end
      prodk_n[a] = AW'(32'(kp1_n[a]) * SRC_GRID);
    end
    meta_n.gam = gam1;
    meta_n.kp1 = kp1_n;
    meta_n.any_zero = (grid1[0] == '0) || (grid1[1] == '0) || (grid1[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        neg2[a] <= prodk_n[a] < AW'(DST_GRID);
        num2[a] <= prodk_n[a] - AW'(DST_GRID);
        lo0_2[a] <= NW'((64'(prodk_n[a] - AW'(DST_GRID)) * 64'(MD)) >> RECIP_SH);
      end
      meta_l[0] <= meta_n;
      for (int i = 1; i < MLEN; i++) begin
        meta_l[i] <= meta_l[i-1];
      end
      ok2 <= 32'(addr1) < 32'(SRC3);
      addr2 <= addr1;
      qb2 <= ADDR_W'((64'(addr1) * 64'(MB)) >> RECIP_SH);
    end
  end

  // Stage 3: correct the quotients to get lower node and weights, and the blue of the write address.
  always_ff @(posedge clk) begin
    logic [AW-1:0] t;
    logic [NW-1:0] lo;
    logic [WW-1:0] wh;
    logic [31:0]   t1;
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        t = num2[a] - AW'(32'(lo0_2[a]) * DST_GRID);
        if (t >= AW'(DST_GRID)) begin
          lo = lo0_2[a] + NW'(1);
          wh = WW'(t - AW'(DST_GRID));
        end else begin
          lo = lo0_2[a];
          wh = WW'(t);
        end
        if (neg2[a]) begin
          lo = '0;
          wh = '0;
        end
        lo3[a] <= lo;
        hi3[a] <= (wh != '0) ? lo + NW'(1) : lo;
        whi3[a] <= wh;
        wlo3[a] <= WW'(DST_GRID) - wh;
      end
      t1 = 32'(addr2) - 32'(qb2) * 32'(SRC2);
      if (t1 >= 32'(SRC2)) begin
        b3 <= NW'(qb2 + ADDR_W'(1));
        rem3 <= R1W'(t1 - 32'(SRC2));
      end else begin
        b3 <= NW'(qb2);
        rem3 <= R1W'(t1);
      end
      ok3 <= ok2;
    end
  end

  // Stages 4 and 5: green and red of the write address; axis data waits.
  always_ff @(posedge clk) begin
    logic [31:0] t2;
    if (adv) begin
      lo4 <= lo3;
      hi4 <= hi3;
      wlo4 <= wlo3;
      whi4 <= whi3;
      lo5 <= lo4;
      hi5 <= hi4;
      wlo5 <= wlo4;
      whi5 <= whi4;
      b4 <= b3;
      rem4 <= rem3;
      qg4 <= NW'((64'(rem3) * 64'(MS)) >> RECIP_SH);
      ok4 <= ok3;
      b5 <= b4;
      ok5 <= ok4;
      t2 = 32'(rem4) - 32'(qg4) * 32'(SRC_GRID);
      if (t2 >= 32'(SRC_GRID)) begin
        g5 <= qg4 + NW'(1);
        r5 <= NW'(t2 - 32'(SRC_GRID));
      end else begin
        g5 <= qg4;
        r5 <= NW'(t2);
      end
    end
  end

  // Stage 6: bank number from the node parities and the address inside it.
  // The range flag travels alongside so that it meets its own write.
  always_ff @(posedge clk) begin
    if (adv) begin
      wpart6 <= BAW'(HW'(r5 >> 1)) + BAW'(BAW'(HW'(g5 >> 1)) * BAW'(HN));
      bh6 <= HW'(b5 >> 1);
      wbank6 <= {b5[0], g5[0], r5[0]};
      ok6 <= ok5;
    end
  end

  assign waddr6 = wpart6 + BAW'(BAW'(bh6) * BAW'(HN * HN));
  assign ram_we = adv && wv[5] && ok6;

  for (genvar c = 0; c < 8; c++) begin : g_lane
    lut3t_lane #(
      .SRC_GRID (SRC_GRID),
      .DST_GRID (DST_GRID),
      .BANK     (c)
    ) u_lane (
      .clk     (clk),
      .en      (adv),
      .node_lo (lo5),
      .node_hi (hi5),
      .w_lo    (wlo5),
      .w_hi    (whi5),
      .wr_en   (ram_we && (wbank6 == 3'(c))),
      .wr_addr (waddr6),
      .wr_data (wd[5]),
      .prod    (lane_prod[c])
    );
  end

  // Registered adder tree merging the eight corner lanes.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int i = 0; i < 4; i++) begin
          sum4[i][ch] <= lane_prod[2*i][ch] + lane_prod[2*i+1][ch];
        end
        for (int i = 0; i < 2; i++) begin
          sum2[i][ch] <= sum4[2*i][ch] + sum4[2*i+1][ch];
        end
        sum1[ch] <= sum2[0][ch] + sum2[1][ch];
      end
    end
  end

  // Pick numerator and denominator of each ratio. A zero gamut uses the corner
  // case scaling when some grid index is zero and gives zero otherwise.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (meta_l[MLEN-1].gam[ch] != '0) begin
          nm12[ch] <= DVW'(sum1[ch] * meta_l[MLEN-1].gam[ch]);
          dm12[ch] <= DVW'(DMC * 64'(meta_l[MLEN-1].kp1[ch]));
          nb12[ch] <= DVW'(sum1[ch]);
          db12[ch] <= DVW'(D3C);
        end else if (meta_l[MLEN-1].any_zero) begin
          nm12[ch] <= DVW'(sum1[ch]);
          dm12[ch] <= DVW'(D3C * 64'(meta_l[MLEN-1].kp1[ch]));
          nb12[ch] <= DVW'(sum1[ch]);
          db12[ch] <= DVW'(D4C);
        end else begin
          nm12[ch] <= '0;
          dm12[ch] <= DVW'(D3C);
          nb12[ch] <= '0;
          db12[ch] <= DVW'(D3C);
        end
      end
    end
  end

  // Saturate the scaled ratio at one, then form (8190 n + d) / (2 d) for both ratios, rounding halves up.
  always_ff @(posedge clk) begin
    logic [DVW-1:0] nc;
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        nc = (nm12[ch] >= dm12[ch]) ? dm12[ch] : nm12[ch];
        nm13[ch] <= ({nc, 13'b0} - {12'b0, nc, 1'b0}) + (DVW+13)'(dm12[ch]);
        dm13[ch] <= {dm12[ch], 1'b0};
        nb13[ch] <= ({nb12[ch], 13'b0} - {12'b0, nb12[ch], 1'b0}) + (DVW+13)'(db12[ch]);
        db13[ch] <= {db12[ch], 1'b0};
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_div
    lut3t_div #(
      .DW (DVW + 1),
      .QW (OUT_W)
    ) u_div_main (
      .clk (clk),
      .en  (adv),
      .num (nm13[ch]),
      .den (dm13[ch]),
      .quo (qm[ch])
    );

    lut3t_div #(
      .DW (DVW + 1),
      .QW (OUT_W)
    ) u_div_byp (
      .clk (clk),
      .en  (adv),
      .num (nb13[ch]),
      .den (db13[ch]),
      .quo (qb[ch])
    );
  end

  assign res = {qb[2], qb[1], qb[0], qm[2], qm[1], qm[0]};
  assign out_free = !out_valid || !out_stall;

  // Output register with a one-entry skid buffer behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_free) begin
      out_valid <= cv[LAT-1];
    end else if (cv[LAT-1]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) begin
        out_data <= skid_data;
      end
    end else if (out_free) begin
      out_data <= res;
    end else begin
      skid_data <= res;
    end
  end

  assign out_red = out_data[0];
  assign out_green = out_data[1];
  assign out_blue = out_data[2];
  assign bypass_red = out_data[3];
  assign bypass_green = out_data[4];
  assign bypass_blue = out_data[5];

endmodule

// ----- hw/rtl/lut3t_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module lut3t_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4913,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/lut3t_div.sv -----
// Pipelined restoring divider giving one quotient bit per stage.
module lut3t_div #(
  parameter int DW = 46,
  parameter int QW = 12
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DW+QW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo
);

  // The upper DW bits of the numerator must already be below the divisor.
  logic [DW-1:0] rem_s [QW];
  logic [DW-1:0] den_s [QW];
  logic [QW-1:0] low_s [QW];
  logic [QW-1:0] quo_s [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in = num[DW+QW-1:QW];
      assign den_in = den;
      assign low_in = num[QW-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_s[i-1];
      assign den_in = den_s[i-1];
      assign low_in = low_s[i-1];
      assign quo_in = quo_s[i-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign take = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i] <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        den_s[i] <= den_in;
        low_s[i] <= {low_in[QW-2:0], 1'b0};
        quo_s[i] <= {quo_in[QW-2:0], take};
      end
    end
  end

  assign quo = quo_s[QW-1];

endmodule

// ----- hw/rtl/lut3t_lane.sv -----
// One corner lane: a parity bank of the source LUT and its weighted product.
module lut3t_lane
  import lut3t_pkg::*;
#(
  parameter int SRC_GRID = 33,
  parameter int DST_GRID = 17,
  parameter int BANK = 0,
  localparam int NW = $clog2(SRC_GRID),
  localparam int WW = $clog2(DST_GRID + 1),
  localparam int HN = (SRC_GRID + 1) / 2,
  localparam int BDEPTH = HN * HN * HN,
  localparam int BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1,
  localparam int PW = $clog2(DST_GRID * DST_GRID * DST_GRID + 1),
  localparam int PRW = VAL_W + PW
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [2:0][NW-1:0]      node_lo,
  input  logic [2:0][NW-1:0]      node_hi,
  input  logic [2:0][WW-1:0]      w_lo,
  input  logic [2:0][WW-1:0]      w_hi,
  input  logic                    wr_en,
  input  logic [BAW-1:0]          wr_addr,
  input  logic [ENTRY_W-1:0]      wr_data,
  output logic [2:0][PRW-1:0]     prod
);

  localparam int HW = (HN > 1) ? $clog2(HN) : 1;
  localparam logic [2:0] BSEL = 3'(BANK);

  logic [2:0][HW-1:0] half;
  logic [2:0][WW-1:0] wsel;
  logic [BAW-1:0]     part_a;
  logic [HW-1:0]      bh_a;
  logic [2*WW-1:0]    wrg_a;
  logic [WW-1:0]      wb_a;
  logic [BAW-1:0]     raddr;
  logic [PW-1:0]      w_b;
  logic [ENTRY_W-1:0] rdata;

  // Each axis takes whichever of its two bracketing nodes has this bank's parity.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (node_lo[a][0] == BSEL[a]) begin
        half[a] = HW'(node_lo[a] >> 1);
        wsel[a] = w_lo[a];
      end else begin
        half[a] = HW'(node_hi[a] >> 1);
        wsel[a] = w_hi[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      part_a <= BAW'(half[0]) + BAW'(BAW'(half[1]) * BAW'(HN));
      bh_a <= half[2];
      wrg_a <= (2*WW)'(wsel[0] * wsel[1]);
      wb_a <= wsel[2];
    end
  end

  assign raddr = part_a + BAW'(BAW'(bh_a) * BAW'(HN * HN));

  always_ff @(posedge clk) begin
    if (en) begin
      w_b <= PW'(wrg_a * wb_a);
    end
  end

  lut3t_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(BDEPTH)
  ) u_bank (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // A zero weight masks the entry, which may never have been written.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod[ch] <= (w_b == '0) ? '0 : PRW'(rdata[ch*VAL_W +: VAL_W] * w_b);
      end
    end
  end

endmodule
